[hw/rtl/gtw_pkg.sv]
`timescale 1ns / 1ps

package gtw_pkg;

    localparam int MAX_RADIUS = 8;
    localparam int GRID_DIM   = 1024;

    localparam int POS_W   = 32;
    localparam int CS_W    = 20;
    localparam int COORD_W = 10;
    localparam int RAD_W   = 4;
    localparam int IDX_W   = 20;
    localparam int CFG_IDX_W = 3;
    localparam int DIV_CNT_W = $clog2(POS_W);

    localparam logic [COORD_W-1:0] GRID_LIM     = COORD_W'(GRID_DIM - 1);
    localparam logic [RAD_W-1:0]   RAD_LIM      = RAD_W'(MAX_RADIUS);
    localparam logic [CS_W-1:0]    CELL_RESET   = CS_W'(10240);
    localparam logic [RAD_W-1:0]   RADIUS_RESET = RAD_W'(8);

    localparam logic AXIS_ROW = 1'b0;
    localparam logic AXIS_COL = 1'b1;

    typedef enum logic [1:0] {
        ST_SPANS     = 2'd0,
        ST_UNCHANGED = 2'd1,
        ST_OUT_GRID  = 2'd2
    } t_status;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ORIGIN_X  = 3'd0,
        CFG_ORIGIN_Y  = 3'd1,
        CFG_CELL_SIZE = 3'd2,
        CFG_MAX_COL   = 3'd3,
        CFG_MAX_ROW   = 3'd4,
        CFG_RADIUS    = 3'd5
    } t_cfg_idx;

    typedef enum logic [1:0] {
        EMIT_NOTE = 2'd0,
        EMIT_ROW  = 2'd1,
        EMIT_COL  = 2'd2
    } t_emit;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DIV,
        S_CLASS,
        S_PLAN,
        S_ROUTE,
        S_NOTE,
        S_ROW_MUL,
        S_ROW_EMIT,
        S_COL_MUL,
        S_COL_EMIT
    } t_state;

    typedef struct packed {
        logic  in_ready;
        logic  load;
        logic  class_en;
        logic  plan_en;
        logic  mul_en;
        logic  mul_col;
        logic  emit;
        t_emit emit_kind;
        logic  emit_last;
        logic  row_inc;
    } t_cmd;

    typedef struct packed {
        logic div_busy;
        logic out_grid;
        logic unchanged;
        logic full;
        logic row_strip;
        logic col_strip;
        logic row_at_end;
        logic out_free;
    } t_stat;

endpackage

[hw/rtl/gtw_div.sv]
`timescale 1ns / 1ps

// Restoring unsigned divider, one quotient bit per cycle.
module gtw_div import gtw_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [POS_W-1:0] i_dividend,
    input  logic [CS_W-1:0]  i_divisor,
    output logic             o_busy,
    output logic [POS_W-1:0] o_quot
);

    logic                 r_busy, n_busy;
    logic [DIV_CNT_W-1:0] r_cnt, n_cnt;
    logic [POS_W-1:0]     r_work, n_work;
    logic [CS_W-1:0]      r_rem, n_rem;
    logic [CS_W-1:0]      r_div, n_div;

    logic [CS_W:0] trial;
    logic [CS_W:0] diff;
    logic          ge;

    assign trial = {r_rem, r_work[POS_W-1]};
    assign diff  = trial - {1'b0, r_div};
    assign ge    = trial >= {1'b0, r_div};

    always_comb begin
        n_busy = r_busy;
        n_cnt  = r_cnt;
        n_work = r_work;
        n_rem  = r_rem;
        n_div  = r_div;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = '0;
            n_work = i_dividend;
            n_rem  = '0;
            n_div  = i_divisor;
        end else if (r_busy) begin
            n_work = {r_work[POS_W-2:0], ge};
            n_rem  = ge ? diff[CS_W-1:0] : trial[CS_W-1:0];
            n_cnt  = r_cnt + 1'b1;
            if (r_cnt == DIV_CNT_W'(POS_W - 1)) begin
                n_busy = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_cnt  <= n_cnt;
        end
        r_work <= n_work;
        r_rem  <= n_rem;
        r_div  <= n_div;
    end

    assign o_busy = r_busy;
    assign o_quot = r_work;

endmodule

[hw/rtl/gtw_datapath.sv]
`timescale 1ns / 1ps

module gtw_datapath import gtw_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_cmd                 i_cmd,
    output t_stat                o_stat,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [POS_W-1:0]     i_cfg_data,
    input  logic signed [POS_W-1:0] i_pos_x,
    input  logic signed [POS_W-1:0] i_pos_y,
    input  logic                 i_mode,
    input  logic                 i_out_ready,
    output logic                 o_out_valid,
    output logic [1:0]           o_status,
    output logic                 o_span_valid,
    output logic                 o_span_axis,
    output logic [COORD_W-1:0]   o_span_fixed,
    output logic [COORD_W-1:0]   o_span_lo,
    output logic [COORD_W-1:0]   o_span_hi,
    output logic [IDX_W-1:0]     o_span_start_index,
    output logic                 o_relocal,
    output logic                 o_last
);

    // configuration
    logic [POS_W-1:0]   r_origin_x, r_origin_y;
    logic [CS_W-1:0]    r_cell_size;
    logic [COORD_W-1:0] r_max_col, r_max_row;
    logic [RAD_W-1:0]   r_radius;

    // tracking state
    logic [COORD_W-1:0] r_last_col, r_last_row;
    logic               r_no_ref, r_relocal;

    // per-item working registers
    logic               r_neg_x, r_neg_y, r_mode;
    logic [COORD_W-1:0] r_col, r_row;
    logic               r_out_grid, r_unchanged, r_full;
    logic [COORD_W-1:0] r_clo, r_chi, r_rlo, r_rhi;
    logic               r_row_strip, r_col_strip;
    logic [COORD_W-1:0] r_strip_col, r_cur_row;
    logic [IDX_W-1:0]   r_prod;

    // result word
    logic               r_out_valid;
    t_status            r_status;
    logic               r_span_valid, r_span_axis;
    logic [COORD_W-1:0] r_span_fixed, r_span_lo, r_span_hi;
    logic [IDX_W-1:0]   r_span_idx;
    logic               r_out_relocal, r_out_last;

    logic [COORD_W-1:0] mc, mr;
    logic [RAD_W-1:0]   rr;
    logic [CS_W-1:0]    cs;

    assign mc = (r_max_col > GRID_LIM) ? GRID_LIM : r_max_col;
    assign mr = (r_max_row > GRID_LIM) ? GRID_LIM : r_max_row;
    assign rr = (r_radius > RAD_LIM) ? RAD_LIM : r_radius;
    assign cs = (r_cell_size == '0) ? CS_W'(1) : r_cell_size;

    // offset from origin, then magnitude for the unsigned divider
    logic [POS_W:0]   dx, dy, dx_neg, dy_neg;
    logic [POS_W-1:0] mag_x, mag_y;

    assign dx     = {i_pos_x[POS_W-1], i_pos_x} - {r_origin_x[POS_W-1], r_origin_x};
    assign dy     = {i_pos_y[POS_W-1], i_pos_y} - {r_origin_y[POS_W-1], r_origin_y};
    assign dx_neg = ~dx + 1'b1;
    assign dy_neg = ~dy + 1'b1;
    assign mag_x  = dx[POS_W] ? dx_neg[POS_W-1:0] : dx[POS_W-1:0];
    assign mag_y  = dy[POS_W] ? dy_neg[POS_W-1:0] : dy[POS_W-1:0];

    logic             busy_x, busy_y;
    logic [POS_W-1:0] q_x, q_y;

    gtw_div u_div_x (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.load),
        .i_dividend (mag_x),
        .i_divisor  (cs),
        .o_busy     (busy_x),
        .o_quot     (q_x)
    );

    gtw_div u_div_y (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.load),
        .i_dividend (mag_y),
        .i_divisor  (cs),
        .o_busy     (busy_y),
        .o_quot     (q_y)
    );

    // classify: a negative offset is in the grid only when it truncates to zero
    logic               x_ok, y_ok;
    logic [COORD_W-1:0] col_c, row_c;

    assign x_ok  = (!r_neg_x || q_x == '0) && (q_x <= POS_W'(mc));
    assign y_ok  = (!r_neg_y || q_y == '0) && (q_y <= POS_W'(mr));
    assign col_c = q_x[COORD_W-1:0];
    assign row_c = q_y[COORD_W-1:0];

    // window bounds and strips
    logic [COORD_W:0]   col_w, row_w, rr_w;
    logic [COORD_W:0]   col_sub, col_add, row_sub, row_add;
    logic               col_ge, row_ge;
    logic [COORD_W-1:0] clo, chi, rlo, rhi;
    logic               row_up, col_up, row_ok, col_ok;
    logic [COORD_W-1:0] strip_row, strip_col;

    assign col_w   = {1'b0, r_col};
    assign row_w   = {1'b0, r_row};
    assign rr_w    = (COORD_W+1)'(rr);
    assign col_sub = col_w - rr_w;
    assign col_add = col_w + rr_w;
    assign row_sub = row_w - rr_w;
    assign row_add = row_w + rr_w;
    assign col_ge  = col_w >= rr_w;
    assign row_ge  = row_w >= rr_w;

    assign clo = col_ge ? col_sub[COORD_W-1:0] : '0;
    assign chi = (col_add > {1'b0, mc}) ? mc : col_add[COORD_W-1:0];
    assign rlo = row_ge ? row_sub[COORD_W-1:0] : '0;
    assign rhi = (row_add > {1'b0, mr}) ? mr : row_add[COORD_W-1:0];

    assign row_up    = r_row > r_last_row;
    assign col_up    = r_col > r_last_col;
    assign row_ok    = row_up ? (row_add <= {1'b0, mr}) : row_ge;
    assign col_ok    = col_up ? (col_add <= {1'b0, mc}) : col_ge;
    assign strip_row = row_up ? row_add[COORD_W-1:0] : row_sub[COORD_W-1:0];
    assign strip_col = col_up ? col_add[COORD_W-1:0] : col_sub[COORD_W-1:0];

    // row times stride, stride = columns
    logic [COORD_W:0]     stride;
    logic [COORD_W-1:0]   mul_a;
    logic [2*COORD_W:0]   prod_w;

    assign stride = {1'b0, mc} + 1'b1;
    assign mul_a  = i_cmd.mul_col ? r_rlo : r_cur_row;
    assign prod_w = (2*COORD_W+1)'(mul_a) * (2*COORD_W+1)'(stride);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_origin_x  <= '0;
            r_origin_y  <= '0;
            r_cell_size <= CELL_RESET;
            r_max_col   <= '0;
            r_max_row   <= '0;
            r_radius    <= RADIUS_RESET;
            r_last_col  <= '0;
            r_last_row  <= '0;
            r_no_ref    <= 1'b1;
            r_relocal   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (t_cfg_idx'(i_cfg_index))
                    CFG_ORIGIN_X:  r_origin_x  <= i_cfg_data;
                    CFG_ORIGIN_Y:  r_origin_y  <= i_cfg_data;
                    CFG_CELL_SIZE: r_cell_size <= i_cfg_data[CS_W-1:0];
                    CFG_MAX_COL:   r_max_col   <= i_cfg_data[COORD_W-1:0];
                    CFG_MAX_ROW:   r_max_row   <= i_cfg_data[COORD_W-1:0];
                    CFG_RADIUS:    r_radius    <= i_cfg_data[RAD_W-1:0];
                    default: ;
                endcase
            end
            if (i_cmd.plan_en) begin
                if (r_out_grid) begin
                    r_relocal <= 1'b1;
                end else begin
                    if (r_mode) begin
                        r_relocal <= 1'b0;
                    end
                    r_last_col <= r_col;
                    r_last_row <= r_row;
                    r_no_ref   <= 1'b0;
                end
            end
            if (i_cmd.emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end

        if (i_cmd.load) begin
            r_neg_x <= dx[POS_W];
            r_neg_y <= dy[POS_W];
            r_mode  <= i_mode;
        end
        if (i_cmd.class_en) begin
            r_col       <= col_c;
            r_row       <= row_c;
            r_out_grid  <= !(x_ok && y_ok);
            r_unchanged <= !r_no_ref && col_c == r_last_col && row_c == r_last_row;
            r_full      <= !r_mode || r_no_ref;
        end
        if (i_cmd.plan_en) begin
            r_clo       <= clo;
            r_chi       <= chi;
            r_rlo       <= rlo;
            r_rhi       <= rhi;
            r_row_strip <= (r_row != r_last_row) && row_ok;
            r_col_strip <= (r_col != r_last_col) && col_ok;
            r_strip_col <= strip_col;
            r_cur_row   <= r_full ? rlo : strip_row;
        end else if (i_cmd.row_inc) begin
            r_cur_row   <= r_cur_row + 1'b1;
        end
        if (i_cmd.mul_en) begin
            r_prod <= prod_w[IDX_W-1:0];
        end
        if (i_cmd.emit) begin
            r_out_relocal <= r_relocal;
            r_out_last    <= i_cmd.emit_last;
            case (i_cmd.emit_kind)
                EMIT_ROW: begin
                    r_status     <= ST_SPANS;
                    r_span_valid <= 1'b1;
                    r_span_axis  <= AXIS_ROW;
                    r_span_fixed <= r_cur_row;
                    r_span_lo    <= r_clo;
                    r_span_hi    <= r_chi;
                    r_span_idx   <= IDX_W'(r_clo) + r_prod;
                end
                EMIT_COL: begin
                    r_status     <= ST_SPANS;
                    r_span_valid <= 1'b1;
                    r_span_axis  <= AXIS_COL;
                    r_span_fixed <= r_strip_col;
                    r_span_lo    <= r_rlo;
                    r_span_hi    <= r_rhi;
                    r_span_idx   <= IDX_W'(r_strip_col) + r_prod;
                end
                default: begin
                    r_status     <= r_out_grid ? ST_OUT_GRID :
                                    r_unchanged ? ST_UNCHANGED : ST_SPANS;
                    r_span_valid <= 1'b0;
                    r_span_axis  <= AXIS_ROW;
                    r_span_fixed <= '0;
                    r_span_lo    <= '0;
                    r_span_hi    <= '0;
                    r_span_idx   <= '0;
                end
            endcase
        end
    end

    always_comb begin
        o_stat.div_busy   = busy_x || busy_y;
        o_stat.out_grid   = r_out_grid;
        o_stat.unchanged  = r_unchanged;
        o_stat.full       = r_full;
        o_stat.row_strip  = r_row_strip;
        o_stat.col_strip  = r_col_strip;
        o_stat.row_at_end = r_cur_row == r_rhi;
        o_stat.out_free   = !r_out_valid || i_out_ready;
    end

    assign o_out_valid        = r_out_valid;
    assign o_status           = r_status;
    assign o_span_valid       = r_span_valid;
    assign o_span_axis        = r_span_axis;
    assign o_span_fixed       = r_span_fixed;
    assign o_span_lo          = r_span_lo;
    assign o_span_hi          = r_span_hi;
    assign o_span_start_index = r_span_idx;
    assign o_relocal          = r_out_relocal;
    assign o_last             = r_out_last;

endmodule

[hw/rtl/gtw_ctrl.sv]
`timescale 1ns / 1ps

module gtw_ctrl import gtw_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) n_state = S_DIV;
            end
            S_DIV: begin
                if (!i_stat.div_busy) n_state = S_CLASS;
            end
            S_CLASS: n_state = S_PLAN;
            S_PLAN:  n_state = S_ROUTE;
            S_ROUTE: begin
                if (i_stat.out_grid || i_stat.unchanged) n_state = S_NOTE;
                else if (i_stat.full || i_stat.row_strip) n_state = S_ROW_MUL;
                else if (i_stat.col_strip)                n_state = S_COL_MUL;
                else                                      n_state = S_NOTE;
            end
            S_NOTE: begin
                if (i_stat.out_free) n_state = S_IDLE;
            end
            S_ROW_MUL: n_state = S_ROW_EMIT;
            S_ROW_EMIT: begin
                if (i_stat.out_free) begin
                    if (i_stat.full) begin
                        n_state = i_stat.row_at_end ? S_IDLE : S_ROW_MUL;
                    end else begin
                        n_state = i_stat.col_strip ? S_COL_MUL : S_IDLE;
                    end
                end
            end
            S_COL_MUL: n_state = S_COL_EMIT;
            S_COL_EMIT: begin
                if (i_stat.out_free) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd           = '0;
        o_cmd.emit_kind = EMIT_NOTE;
        case (r_state)
            S_IDLE: begin
                o_cmd.in_ready = 1'b1;
                o_cmd.load     = i_in_valid;
            end
            S_CLASS: o_cmd.class_en = 1'b1;
            S_PLAN:  o_cmd.plan_en  = 1'b1;
            S_NOTE: begin
                o_cmd.emit      = i_stat.out_free;
                o_cmd.emit_last = 1'b1;
            end
            S_ROW_MUL: o_cmd.mul_en = 1'b1;
            S_ROW_EMIT: begin
                o_cmd.emit      = i_stat.out_free;
                o_cmd.emit_kind = EMIT_ROW;
                o_cmd.emit_last = i_stat.full ? i_stat.row_at_end : !i_stat.col_strip;
                o_cmd.row_inc   = i_stat.out_free && i_stat.full && !i_stat.row_at_end;
            end
            S_COL_MUL: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_col = 1'b1;
            end
            S_COL_EMIT: begin
                o_cmd.emit      = i_stat.out_free;
                o_cmd.emit_kind = EMIT_COL;
                o_cmd.emit_last = 1'b1;
            end
            default: ;
        endcase
    end

endmodule

[hw/rtl/grid_tile_window_tracker.sv]
`timescale 1ns / 1ps

// Grid tile window tracker. Each input word (pos_x, pos_y, mode) is turned into
// a grid cell, (pos - origin) / cell_size truncated toward zero, and then into
// one or more result words: a single status word for out of grid (status 2,
// relocal set) or unchanged cell (status 1), the clipped window as row spans
// in full mode, or only the newly entered row strip then column strip in
// incremental mode (incremental acts as full until a first cell is known).
// A bare status 0 word stands in when both incremental strips are clipped
// away. Each span carries its linear tile index col + row * (max_col + 1);
// the word with last set ends the item. One item is in work at a time. The
// two axes are divided in parallel by bit-serial dividers; after the divide
// the item is classified and its window planned, and each span then passes
// through a state that forms the row times stride product and a state that
// loads the output register, which waits while the result side stalls. A
// full window has up to 17 rows. The output register lets the next item be
// accepted while the last result word of the previous one still waits.
// Configuration writes are always ready and should only be issued while no item is in work.
module grid_tile_window_tracker import gtw_pkg::*; (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    // configuration write channel
    input  logic                    i_cfg_valid,
    output logic                    o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [POS_W-1:0]        i_cfg_data,
    // input words
    input  logic                    i_in_valid,
    output logic                    o_in_ready,
    input  logic signed [POS_W-1:0] i_pos_x,
    input  logic signed [POS_W-1:0] i_pos_y,
    input  logic                    i_mode,
    // result words
    output logic                    o_out_valid,
    input  logic                    i_out_ready,
    output logic [1:0]              o_status,
    output logic                    o_span_valid,
    output logic                    o_span_axis,
    output logic [COORD_W-1:0]      o_span_fixed,
    output logic [COORD_W-1:0]      o_span_lo,
    output logic [COORD_W-1:0]      o_span_hi,
    output logic [IDX_W-1:0]        o_span_start_index,
    output logic                    o_relocal,
    output logic                    o_last
);

    t_cmd  cmd;
    t_stat stat;

    // registers are plain flops, a write never has to wait
    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = cmd.in_ready;

    gtw_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    gtw_datapath u_dp (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cmd              (cmd),
        .o_stat             (stat),
        .i_cfg_we           (i_cfg_valid),
        .i_cfg_index        (i_cfg_index),
        .i_cfg_data         (i_cfg_data),
        .i_pos_x            (i_pos_x),
        .i_pos_y            (i_pos_y),
        .i_mode             (i_mode),
        .i_out_ready        (i_out_ready),
        .o_out_valid        (o_out_valid),
        .o_status           (o_status),
        .o_span_valid       (o_span_valid),
        .o_span_axis        (o_span_axis),
        .o_span_fixed       (o_span_fixed),
        .o_span_lo          (o_span_lo),
        .o_span_hi          (o_span_hi),
        .o_span_start_index (o_span_start_index),
        .o_relocal          (o_relocal),
        .o_last             (o_last)
    );

    // once an item is taken, the next one waits for the divide to run
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("input taken twice in a row");

    // out of grid is a lone word with the relocalise flag raised
    a_out_grid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status == ST_OUT_GRID) |-> (o_last && o_relocal && !o_span_valid))
        else $error("out of grid word malformed");

    // status-only words always close their item
    a_note_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_span_valid) |-> o_last)
        else $error("word without span not marked last");

    // clipped spans are never empty
    a_span_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_span_valid) |-> (o_span_lo <= o_span_hi && o_status == ST_SPANS))
        else $error("span bounds out of order");

endmodule

[test/tb_top.sv]
`timescale 1ns / 1ps

// Self-checking bench for the grid tile window tracker.
// A cell predictor runs on every accepted input word and queues the result
// words it expects; a monitor pops one per accepted result word and compares
// every field.
module tb_top;
    import gtw_pkg::*;

    localparam logic MODE_FULL = 1'b0;
    localparam logic MODE_INCR = 1'b1;

    // one expected result word
    typedef struct {
        t_status             status;
        logic                span_valid;
        logic                span_axis;
        logic [COORD_W-1:0]  fixed;
        logic [COORD_W-1:0]  lo;
        logic [COORD_W-1:0]  hi;
        logic [IDX_W-1:0]    start_index;
        logic                relocal;
        logic                last;
    } t_word;

    // ---------------------------------------------------------------------
    // DUT ports; every input starts at a known value
    // ---------------------------------------------------------------------
    logic                    i_clk = 1'b0;
    logic                    i_rst_n = 1'b0;
    logic                    i_cfg_valid = 1'b0;
    logic                    o_cfg_ready;
    logic [CFG_IDX_W-1:0]    i_cfg_index = '0;
    logic [POS_W-1:0]        i_cfg_data = '0;
    logic                    i_in_valid = 1'b0;
    logic                    o_in_ready;
    logic signed [POS_W-1:0] i_pos_x = '0;
    logic signed [POS_W-1:0] i_pos_y = '0;
    logic                    i_mode = 1'b0;
    logic                    o_out_valid;
    logic                    i_out_ready = 1'b0;
    logic [1:0]              o_status;
    logic                    o_span_valid;
    logic                    o_span_axis;
    logic [COORD_W-1:0]      o_span_fixed;
    logic [COORD_W-1:0]      o_span_lo;
    logic [COORD_W-1:0]      o_span_hi;
    logic [IDX_W-1:0]        o_span_start_index;
    logic                    o_relocal;
    logic                    o_last;

    grid_tile_window_tracker i_dut (.*);

    // ---------------------------------------------------------------------
    // bench state
    // ---------------------------------------------------------------------
    t_word due_words[$];      // result words still to come, oldest first
    int    fail_count  = 0;
    int    tx_idle_pct = 26;  // chance per word that the sender leaves a gap
    int    rx_idle_pct = 55;  // chance per cycle that the receiver stalls

    // predictor copy of the registers (reset values)
    logic signed [POS_W-1:0] map_origin_x = '0;
    logic signed [POS_W-1:0] map_origin_y = '0;
    logic [CS_W-1:0]         tile_size    = CELL_RESET;
    logic [COORD_W-1:0]      col_limit    = '0;
    logic [COORD_W-1:0]      row_limit    = '0;
    logic [RAD_W-1:0]        win_radius   = RADIUS_RESET;

    // predictor copy of the tracking state
    logic [COORD_W-1:0]      anchor_col       = '0;
    logic [COORD_W-1:0]      anchor_row       = '0;
    logic                    anchor_known     = 1'b0;
    logic                    relocate_pending = 1'b0;

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // watchdog, far above the slowest legal run
    initial begin
        #2_000_000;
        $display("TEST FAILED");
        $finish;
    end

    // receiver back-pressure, redrawn every cycle
    always @(posedge i_clk) begin
        i_out_ready <= ($urandom_range(99) >= rx_idle_pct);
    end

    // ---------------------------------------------------------------------
    // predictor
    // ---------------------------------------------------------------------
    function automatic t_word make_word(input t_status st, input logic has_span,
                                        input logic axis, input longint fixed,
                                        input longint lo, input longint hi,
                                        input longint idx);
        t_word w;
        w.status      = st;
        w.span_valid  = has_span;
        w.span_axis   = axis;
        w.fixed       = fixed[COORD_W-1:0];
        w.lo          = lo[COORD_W-1:0];
        w.hi          = hi[COORD_W-1:0];
        w.start_index = idx[IDX_W-1:0];
        w.relocal     = relocate_pending;  // flag as it stands after this step
        w.last        = 1'b0;
        return w;
    endfunction

    // Appends one word at the tail of a word queue.
    function automatic void add_word(ref t_word q[$], input t_word w);
        q.insert(q.size(), w);
    endfunction

    // Works out the result words of one input word and queues them.
    function automatic void predict_tiles(input logic signed [POS_W-1:0] px,
                                          input logic signed [POS_W-1:0] py,
                                          input logic incr);
        longint cs, mc, mr, stride, rad, col, row, lc, lr, lo, hi, j;
        t_word  words[$];
        t_word  w;
        cs     = (tile_size == 0) ? 1 : longint'(tile_size);
        mc     = (col_limit > GRID_LIM) ? longint'(GRID_LIM) : longint'(col_limit);
        mr     = (row_limit > GRID_LIM) ? longint'(GRID_LIM) : longint'(row_limit);
        stride = mc + 1;
        rad    = (win_radius > RAD_LIM) ? longint'(RAD_LIM) : longint'(win_radius);
        // signed division truncates toward zero
        col    = (longint'(px) - longint'(map_origin_x)) / cs;
        row    = (longint'(py) - longint'(map_origin_y)) / cs;
        lc     = longint'(anchor_col);
        lr     = longint'(anchor_row);

        if (col < 0 || col > mc || row < 0 || row > mr) begin
            // off the map: flag it, keep the anchor cell
            relocate_pending = 1'b1;
            add_word(words, make_word(ST_OUT_GRID, 1'b0, AXIS_ROW, 0, 0, 0, 0));
        end else begin
            if (incr)
                relocate_pending = 1'b0;
            if (anchor_known && col == lc && row == lr) begin
                add_word(words, make_word(ST_UNCHANGED, 1'b0, AXIS_ROW, 0, 0, 0, 0));
            end else begin
                if (!incr || !anchor_known) begin
                    // whole window as row spans
                    lo = (col - rad < 0) ? 0 : col - rad;
                    hi = (col + rad > mc) ? mc : col + rad;
                    for (j = row - rad; j <= row + rad; j++) begin
                        if (j >= 0 && j <= mr)
                            add_word(words, make_word(ST_SPANS, 1'b1, AXIS_ROW, j, lo, hi,
                                                      lo + j * stride));
                    end
                end else begin
                    // leading row strip first, then leading column strip
                    if (row != lr) begin
                        j  = (row > lr) ? row + rad : row - rad;
                        lo = (col - rad < 0) ? 0 : col - rad;
                        hi = (col + rad > mc) ? mc : col + rad;
                        if (j >= 0 && j <= mr)
                            add_word(words, make_word(ST_SPANS, 1'b1, AXIS_ROW, j, lo, hi,
                                                      lo + j * stride));
                    end
                    if (col != lc) begin
                        j  = (col > lc) ? col + rad : col - rad;
                        lo = (row - rad < 0) ? 0 : row - rad;
                        hi = (row + rad > mr) ? mr : row + rad;
                        if (j >= 0 && j <= mc)
                            add_word(words, make_word(ST_SPANS, 1'b1, AXIS_COL, j, lo, hi,
                                                      j + lo * stride));
                    end
                end
                anchor_col   = col[COORD_W-1:0];
                anchor_row   = row[COORD_W-1:0];
                anchor_known = 1'b1;
                // both strips clipped away: a bare status word
                if (words.size() == 0)
                    add_word(words, make_word(ST_SPANS, 1'b0, AXIS_ROW, 0, 0, 0, 0));
            end
        end

        w      = words.pop_back();
        w.last = 1'b1;
        add_word(words, w);
        foreach (words[k])
            add_word(due_words, words[k]);
    endfunction

    // A position somewhere inside cell c of one axis, under the current map.
    // Cell 0 sometimes gets a small negative offset, which still truncates to 0.
    function automatic logic signed [POS_W-1:0] pos_in_cell(input longint c,
                                                            input logic signed [POS_W-1:0] org);
        longint cs, frac, p;
        cs   = (tile_size == 0) ? 1 : longint'(tile_size);
        frac = $urandom_range(int'(cs) - 1, 0);
        if (c < 0 || (c == 0 && $urandom_range(1) == 1))
            p = longint'(org) + c * cs - frac;
        else
            p = longint'(org) + c * cs + frac;
        return p[POS_W-1:0];
    endfunction

    // ---------------------------------------------------------------------
    // result monitor
    // ---------------------------------------------------------------------
    function automatic void check_field(input string name, input longint unsigned want,
                                        input longint unsigned got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
            fail_count++;
        end
    endfunction

    always @(posedge i_clk) begin
        t_word w;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (due_words.size() == 0) begin
                $display("%0t: unexpected result word, expected none, got status %0d",
                         $time, o_status);
                fail_count++;
            end else begin
                w = due_words.pop_front();
                check_field("status", w.status, o_status);
                check_field("span_valid", w.span_valid, o_span_valid);
                check_field("span_axis", w.span_axis, o_span_axis);
                check_field("span_fixed", w.fixed, o_span_fixed);
                check_field("span_lo", w.lo, o_span_lo);
                check_field("span_hi", w.hi, o_span_hi);
                check_field("span_start_index", w.start_index, o_span_start_index);
                check_field("relocal", w.relocal, o_relocal);
                check_field("last", w.last, o_last);
            end
        end
    end

    // ---------------------------------------------------------------------
    // drivers
    // ---------------------------------------------------------------------
    // Valid stays up from one word to the next unless a gap is drawn, so a
    // step never sees valid both lowered and raised.
    task automatic send_word(input logic signed [POS_W-1:0] px,
                             input logic signed [POS_W-1:0] py, input logic incr);
        int gap;
        if ($urandom_range(99) < tx_idle_pct) begin
            gap = $urandom_range(1, 6);
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_pos_x    <= px;
        i_pos_y    <= py;
        i_mode     <= incr;
        do @(posedge i_clk); while (!o_in_ready);
        predict_tiles(px, py, incr);
    endtask

    // Stop sending and wait until every expected word has come back.
    // Every input yields at least one word, so the block is idle after that.
    task automatic drain_results();
        i_in_valid <= 1'b0;
        while (due_words.size() != 0)
            @(posedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic [POS_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            CFG_ORIGIN_X:  map_origin_x = data;
            CFG_ORIGIN_Y:  map_origin_y = data;
            CFG_CELL_SIZE: tile_size    = data[CS_W-1:0];
            CFG_MAX_COL:   col_limit    = data[COORD_W-1:0];
            CFG_MAX_ROW:   row_limit    = data[COORD_W-1:0];
            CFG_RADIUS:    win_radius   = data[RAD_W-1:0];
            default: ;
        endcase
    endtask

    // Only call with the block idle (after drain_results).
    task automatic set_config(input logic [POS_W-1:0] ox, input logic [POS_W-1:0] oy,
                              input logic [POS_W-1:0] cs, input logic [POS_W-1:0] mc,
                              input logic [POS_W-1:0] mr, input logic [POS_W-1:0] rad);
        write_reg(CFG_ORIGIN_X, ox);
        write_reg(CFG_ORIGIN_Y, oy);
        write_reg(CFG_CELL_SIZE, cs);
        write_reg(CFG_MAX_COL, mc);
        write_reg(CFG_MAX_ROW, mr);
        write_reg(CFG_RADIUS, rad);
        i_cfg_valid <= 1'b0;
    endtask

    // ---------------------------------------------------------------------
    // tests
    // ---------------------------------------------------------------------
    // Register reset values: a 1x1 grid of 10 m tiles, radius 8.
    task automatic test_reset_defaults();
        send_word(32'sd5000, 32'sd5000, MODE_INCR);   // no anchor yet: full window
        send_word(32'sd9000, 32'sd100, MODE_FULL);    // same cell
        send_word(32'sd10240, 32'sd0, MODE_FULL);     // column 1 is off the map
        send_word(-32'sd5, -32'sd5, MODE_INCR);       // truncates to cell 0, clears flag
    endtask

    // 100x100 grid, 10 m tiles, full radius: windows, strips, clipping.
    task automatic test_window_moves();
        drain_results();
        set_config(32'd0, 32'd0, 32'd10240, 32'd99, 32'd99, 32'd8);
        send_word(pos_in_cell(50, map_origin_x), pos_in_cell(50, map_origin_y), MODE_FULL);
        send_word(pos_in_cell(51, map_origin_x), pos_in_cell(50, map_origin_y), MODE_INCR);
        send_word(pos_in_cell(52, map_origin_x), pos_in_cell(51, map_origin_y), MODE_INCR);
        send_word(pos_in_cell(50, map_origin_x), pos_in_cell(49, map_origin_y), MODE_INCR);
        // corner window, then strips that fall off the low edges
        send_word(pos_in_cell(0, map_origin_x), pos_in_cell(0, map_origin_y), MODE_FULL);
        send_word(pos_in_cell(0, map_origin_x), pos_in_cell(1, map_origin_y), MODE_INCR);
        send_word(pos_in_cell(1, map_origin_x), pos_in_cell(0, map_origin_y), MODE_INCR);
        send_word(pos_in_cell(0, map_origin_x), pos_in_cell(0, map_origin_y), MODE_INCR);
        // far corner, strips off the high edges
        send_word(pos_in_cell(99, map_origin_x), pos_in_cell(99, map_origin_y), MODE_FULL);
        send_word(pos_in_cell(99, map_origin_x), pos_in_cell(98, map_origin_y), MODE_INCR);
        // relocalise flag: set off-map, kept by full mode, cleared by incremental
        send_word(pos_in_cell(100, map_origin_x), pos_in_cell(5, map_origin_y), MODE_INCR);
        send_word(pos_in_cell(5, map_origin_x), pos_in_cell(5, map_origin_y), MODE_FULL);
        send_word(pos_in_cell(5, map_origin_x), pos_in_cell(-1, map_origin_y), MODE_FULL);
        send_word(pos_in_cell(5, map_origin_x), pos_in_cell(5, map_origin_y), MODE_INCR);
        send_word(32'sh7FFF_FFFF, 32'sh8000_0000, MODE_INCR);
    endtask

    // Register and position extremes, out-of-range register data.
    task automatic test_config_extremes();
        drain_results();
        // cell size data masks to 0 (acts as 1), radius 15 clamps to 8
        set_config(32'h8000_0000, 32'h7FFF_FFFF, 32'hFFF0_0000, 32'd1023,
                   32'hFFFF_FC00, 32'hFFFF_FFFF);
        send_word(32'sh8000_03E8, 32'sh7FFF_FFFF, MODE_FULL);
        send_word(32'sh8000_03FF, 32'sh7FFF_FFFF, MODE_INCR);   // column strip clipped
        send_word(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, MODE_INCR);
        drain_results();
        // largest tile, single column, tallest grid, radius 0
        set_config(32'd0, 32'd0, 32'd1048575, 32'd0, 32'd1023, 32'd0);
        send_word(-32'sd1000, pos_in_cell(1023, map_origin_y), MODE_FULL);
        send_word(-32'sd1000, pos_in_cell(1022, map_origin_y), MODE_INCR);
        send_word(32'sh8000_0000, 32'sd0, MODE_FULL);
    endtask

    // Random map, then a vehicle random walk with occasional jumps and
    // noise words. Halfway the sender waits for all results.
    task automatic test_random_walk(input int tx_pct, input int rx_pct, input int n_words);
        logic [POS_W-1:0] ox, oy, cs;
        longint           mc, mr, c, r;
        int               pick;
        drain_results();
        tx_idle_pct = tx_pct;
        rx_idle_pct = rx_pct;
        // keep origin + whole map inside the 32-bit range
        ox = $unsigned(int'($urandom) >>> 2);
        oy = $unsigned(int'($urandom) >>> 2);
        case ($urandom_range(2))
            0:       cs = $urandom_range(4000, 1);
            1:       cs = $urandom_range(1048575, 1);
            default: cs = 32'd10240;
        endcase
        mc = ($urandom_range(3) == 0) ? 1023 : $urandom_range(40, 0);
        mr = ($urandom_range(3) == 0) ? 1023 : $urandom_range(40, 0);
        set_config(ox, oy, cs, POS_W'(mc), POS_W'(mr), $urandom_range(15, 0));
        c = $urandom_range(int'(mc), 0);
        r = $urandom_range(int'(mr), 0);
        for (int k = 0; k < n_words; k++) begin
            if (k == n_words / 2)
                drain_results();
            pick = $urandom_range(99);
            if (pick < 8) begin
                send_word($urandom, $urandom, 1'($urandom_range(1)));
            end else begin
                if (pick < 14) begin
                    c = $urandom_range(int'(mc), 0);
                    r = $urandom_range(int'(mr), 0);
                end else begin
                    c = c + $urandom_range(4) - 2;
                    r = r + $urandom_range(4) - 2;
                end
                // wander at most one cell off the map
                if (c < -1) c = -1;
                if (c > mc + 1) c = mc + 1;
                if (r < -1) r = -1;
                if (r > mr + 1) r = mr + 1;
                send_word(pos_in_cell(c, map_origin_x), pos_in_cell(r, map_origin_y),
                          (pick < 35) ? MODE_FULL : MODE_INCR);
            end
        end
    endtask

    task automatic finish_run();
        drain_results();
        repeat (200) @(posedge i_clk);
        if (fail_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    endtask

    // ---------------------------------------------------------------------
    // sequence
    // ---------------------------------------------------------------------
    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_reset_defaults();
        test_window_moves();
        test_config_extremes();
        test_random_walk(26, 55, 32);
        test_random_walk(55, 26, 32);
        test_random_walk(0, 0, 32);
        finish_run();
    end

endmodule

[sim.f]
hw/rtl/gtw_pkg.sv
hw/rtl/gtw_div.sv
hw/rtl/gtw_datapath.sv
hw/rtl/gtw_ctrl.sv
hw/rtl/grid_tile_window_tracker.sv
test/tb_top.sv
